[hdl/sawbd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sawbd_pkg
// Shared types and constants for the ramp generator with wrap and bounce.
// ----------------------------------------------------------------------------
package sawbd_pkg;

   // Fixed-point format of value, step and limits
   localparam int VALUE_WIDTH = 32;
   localparam int FRAC_BITS   = 16;
   localparam int DECAY_WIDTH = FRAC_BITS + 1;

   // Width used for limit arithmetic: sum plus doubled limit headroom
   localparam int WIDE_WIDTH  = VALUE_WIDTH + 3;
   // Product of signed step and non-negative decay factor
   localparam int PROD_WIDTH  = VALUE_WIDTH + DECAY_WIDTH + 1;

   localparam logic [DECAY_WIDTH-1:0] DECAY_ONE = DECAY_WIDTH'(1) << FRAC_BITS;
   localparam logic signed [VALUE_WIDTH-1:0] VALUE_MAX =
      {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   localparam logic signed [VALUE_WIDTH-1:0] VALUE_MIN =
      {1'b1, {(VALUE_WIDTH-1){1'b0}}};

   // Register reset values
   localparam logic signed [VALUE_WIDTH-1:0] UPPER_RESET =
      VALUE_WIDTH'(1) << FRAC_BITS;

   // Operating modes
   typedef enum logic [1:0] {
      MODE_PLAIN  = 2'd0,
      MODE_DECAY  = 2'd1,
      MODE_WRAP   = 2'd2,
      MODE_BOUNCE = 2'd3
   } mode_type;

   // Item functions
   localparam logic FUNC_TICK   = 1'b0;
   localparam logic FUNC_PRESET = 1'b1;

   // Register map
   localparam int CSR_INDEX_WIDTH = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MODE         = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_STEP   = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DECAY_FACTOR = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LOWER_LIMIT  = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UPPER_LIMIT  = 3'd4;

   // Configuration seen by the datapath
   typedef struct packed {
      mode_type                        mode;
      logic signed [VALUE_WIDTH-1:0]   start_step;
      logic        [DECAY_WIDTH-1:0]   decay_factor;
      logic signed [VALUE_WIDTH-1:0]   lower_limit;
      logic signed [VALUE_WIDTH-1:0]   upper_limit;
   } cfg_type;

   // One result beat plus the new state
   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0]   value;
      logic signed [VALUE_WIDTH-1:0]   step;
      logic                            wrapped;
      logic                            reversed;
      logic                            saturated;
   } result_type;

endpackage

[hdl/sawbd_csr.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sawbd_csr
// Configuration register file; always ready, one register per write beat.
// ----------------------------------------------------------------------------
module sawbd_csr (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        csr_valid,
   output logic                                        csr_ready,
   input  logic [sawbd_pkg::CSR_INDEX_WIDTH-1:0]       csr_index,
   input  logic [sawbd_pkg::VALUE_WIDTH-1:0]           csr_wdata,
   output sawbd_pkg::cfg_type                          cfg
);

   sawbd_pkg::cfg_type cfg_ff;
   sawbd_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Decode write beat; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            sawbd_pkg::CSR_MODE:
               cfg_in.mode = sawbd_pkg::mode_type'(csr_wdata[1:0]);
            sawbd_pkg::CSR_START_STEP:
               cfg_in.start_step = csr_wdata;
            sawbd_pkg::CSR_DECAY_FACTOR:
               cfg_in.decay_factor = csr_wdata[sawbd_pkg::DECAY_WIDTH-1:0];
            sawbd_pkg::CSR_LOWER_LIMIT:
               cfg_in.lower_limit = csr_wdata;
            sawbd_pkg::CSR_UPPER_LIMIT:
               cfg_in.upper_limit = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode         <= sawbd_pkg::MODE_PLAIN;
         cfg_ff.start_step   <= '0;
         cfg_ff.decay_factor <= sawbd_pkg::DECAY_ONE;
         cfg_ff.lower_limit  <= '0;
         cfg_ff.upper_limit  <= sawbd_pkg::UPPER_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[hdl/sawbd_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sawbd_step
// Next-state logic: accumulate, decay the step, wrap/bounce/saturate.
// ----------------------------------------------------------------------------
module sawbd_step (
   input  sawbd_pkg::cfg_type                          cfg,
   input  logic                                        func,
   input  logic signed [sawbd_pkg::VALUE_WIDTH-1:0]    preset_value,
   input  logic signed [sawbd_pkg::VALUE_WIDTH-1:0]    value,
   input  logic signed [sawbd_pkg::VALUE_WIDTH-1:0]    step,
   output sawbd_pkg::result_type                       result
);

   localparam int VW = sawbd_pkg::VALUE_WIDTH;
   localparam int WW = sawbd_pkg::WIDE_WIDTH;
   localparam int FB = sawbd_pkg::FRAC_BITS;
   localparam int DW = sawbd_pkg::DECAY_WIDTH;
   localparam int PW = sawbd_pkg::PROD_WIDTH;

   logic        [DW-1:0]   factor;
   logic signed [PW-1:0]   product;
   logic signed [VW-1:0]   decayed;
   logic signed [VW-1:0]   negated;
   logic signed [VW:0]     sum;
   logic signed [WW-1:0]   sum_w;
   logic signed [VW-1:0]   lo;
   logic signed [VW-1:0]   hi;
   logic signed [WW-1:0]   lo_w;
   logic signed [WW-1:0]   hi_w;
   logic                   at_hi;
   logic                   at_lo;
   logic signed [WW-1:0]   fold;
   logic signed [WW-1:0]   clipped;
   logic signed [VW-1:0]   sat_value;
   logic                   overflow;

   // Step decay: factor above 1.0 acts as 1.0, product floored
   assign factor  = (cfg.decay_factor > sawbd_pkg::DECAY_ONE) ?
                    sawbd_pkg::DECAY_ONE : cfg.decay_factor;
   assign product = PW'(step) * $signed({1'b0, factor});
   assign decayed = product[FB +: VW];
   assign negated = (decayed == sawbd_pkg::VALUE_MIN) ? sawbd_pkg::VALUE_MAX
                                                       : -decayed;

   // Full-precision sum and ordered limits
   assign sum   = (VW+1)'(value) + (VW+1)'(step);
   assign sum_w = WW'(sum);
   assign lo    = (cfg.lower_limit > cfg.upper_limit) ? cfg.upper_limit
                                                      : cfg.lower_limit;
   assign hi    = (cfg.lower_limit > cfg.upper_limit) ? cfg.lower_limit
                                                      : cfg.upper_limit;
   assign lo_w  = WW'(lo);
   assign hi_w  = WW'(hi);
   assign at_hi = (sum_w >= hi_w);
   assign at_lo = !at_hi && (sum_w <= lo_w);

   // Unbounded modes: clip to number range
   assign overflow  = (sum[VW] != sum[VW-1]);
   assign sat_value = !overflow ? sum[VW-1:0] :
                      (sum[VW] ? sawbd_pkg::VALUE_MIN : sawbd_pkg::VALUE_MAX);

   // Single wrap or reflection at a limit
   always_comb begin
      fold = sum_w;
      if (cfg.mode == sawbd_pkg::MODE_WRAP) begin
         if (at_hi) begin
            fold = sum_w - hi_w + lo_w;
         end else if (at_lo) begin
            fold = sum_w + hi_w - lo_w;
         end
      end else begin
         if (at_hi) begin
            fold = (hi_w <<< 1) - sum_w;
         end else if (at_lo) begin
            fold = (lo_w <<< 1) - sum_w;
         end
      end
   end

   // Overshoot past the span is pinned into the limits
   always_comb begin
      if (fold < lo_w) begin
         clipped = lo_w;
      end else if (fold > hi_w) begin
         clipped = hi_w;
      end else begin
         clipped = fold;
      end
   end

   // Result select
   always_comb begin
      result.value     = value;
      result.step      = step;
      result.wrapped   = 1'b0;
      result.reversed  = 1'b0;
      result.saturated = 1'b0;
      if (func == sawbd_pkg::FUNC_PRESET) begin
         result.value = preset_value;
         result.step  = cfg.start_step;
      end else begin
         case (cfg.mode)
            sawbd_pkg::MODE_PLAIN: begin
               result.value     = sat_value;
               result.saturated = overflow;
            end
            sawbd_pkg::MODE_DECAY: begin
               result.value     = sat_value;
               result.step      = decayed;
               result.saturated = overflow;
            end
            sawbd_pkg::MODE_WRAP: begin
               result.value   = clipped[VW-1:0];
               result.step    = decayed;
               result.wrapped = at_hi || at_lo;
            end
            sawbd_pkg::MODE_BOUNCE: begin
               result.value    = clipped[VW-1:0];
               result.step     = (at_hi || at_lo) ? negated : decayed;
               result.reversed = at_hi || at_lo;
            end
            default: ;
         endcase
      end
   end

endmodule

[hdl/step_accumulator_wrap_bounce_decay.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// step_accumulator_wrap_bounce_decay
// Q16.16 ramp generator: accumulate, decay, wrap or bounce between limits.
// ----------------------------------------------------------------------------
// Accepts one beat per clock and returns exactly one result beat per input
// beat, in order. A beat is captured in an input register; from there one
// pass of logic (a 32x18 multiply for the step decay, the 33-bit sum, the
// limit compares and a fold/clip) updates the running value and step and
// loads the result register, from which the result is presented. Throughput
// is one item per cycle; it stalls only while the result register is held
// by rsp_ready. The configuration port is always ready; write it while the
// block is idle.
// ----------------------------------------------------------------------------
module step_accumulator_wrap_bounce_decay (
   input  logic                                        clock,
   input  logic                                        reset,
   // item channel
   input  logic                                        req_valid,
   output logic                                        req_ready,
   input  logic                                        req_func,
   input  logic signed [sawbd_pkg::VALUE_WIDTH-1:0]    req_preset_value,
   // result channel
   output logic                                        rsp_valid,
   input  logic                                        rsp_ready,
   output logic signed [sawbd_pkg::VALUE_WIDTH-1:0]    rsp_value_out,
   output logic signed [sawbd_pkg::VALUE_WIDTH-1:0]    rsp_step_out,
   output logic                                        rsp_wrapped,
   output logic                                        rsp_reversed,
   output logic                                        rsp_saturated,
   // configuration channel
   input  logic                                        csr_valid,
   output logic                                        csr_ready,
   input  logic [sawbd_pkg::CSR_INDEX_WIDTH-1:0]       csr_index,
   input  logic [sawbd_pkg::VALUE_WIDTH-1:0]           csr_wdata
);

   localparam int VW = sawbd_pkg::VALUE_WIDTH;

   sawbd_pkg::cfg_type      cfg;
   sawbd_pkg::result_type   result;

   logic                    in_valid_ff;
   logic                    in_func_ff;
   logic signed [VW-1:0]    in_preset_ff;
   logic signed [VW-1:0]    value_ff;
   logic signed [VW-1:0]    step_ff;
   logic                    out_valid_ff;
   sawbd_pkg::result_type   out_ff;
   logic                    advance;

   sawbd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sawbd_step u_step (
      .cfg          (cfg),
      .func         (in_func_ff),
      .preset_value (in_preset_ff),
      .value        (value_ff),
      .step         (step_ff),
      .result       (result)
   );

   // Pipeline control: the input stage moves on when the result slot frees
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_func_ff   <= req_func;
         in_preset_ff <= req_preset_value;
      end
   end

   // Running state
   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
         step_ff  <= '0;
      end else if (advance) begin
         value_ff <= result.value;
         step_ff  <= result.step;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_value_out = out_ff.value;
   assign rsp_step_out  = out_ff.step;
   assign rsp_wrapped   = out_ff.wrapped;
   assign rsp_reversed  = out_ff.reversed;
   assign rsp_saturated = out_ff.saturated;

endmodule

[tb/sawbd_ramp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sawbd_ramp_checker
// Passive checker for the Q16.16 ramp generator with wrap and bounce.
// ----------------------------------------------------------------------------
// Watches the register, item and result channels at the rising clock edge.
// Keeps a shadow copy of the registers and of the running value and step,
// works out the result of every accepted item beat and queues it. Each
// accepted result beat is compared field by field with the oldest queued
// result. The failure count and the number of results still owed go back to
// the testbench top.
// ----------------------------------------------------------------------------
module sawbd_ramp_checker (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   input  logic                                        req_ready,
   input  logic                                        req_func,
   input  logic signed [sawbd_pkg::VALUE_WIDTH-1:0]    req_preset_value,
   input  logic                                        rsp_valid,
   input  logic                                        rsp_ready,
   input  logic signed [sawbd_pkg::VALUE_WIDTH-1:0]    rsp_value_out,
   input  logic signed [sawbd_pkg::VALUE_WIDTH-1:0]    rsp_step_out,
   input  logic                                        rsp_wrapped,
   input  logic                                        rsp_reversed,
   input  logic                                        rsp_saturated,
   input  logic                                        csr_valid,
   input  logic                                        csr_ready,
   input  logic [sawbd_pkg::CSR_INDEX_WIDTH-1:0]       csr_index,
   input  logic [sawbd_pkg::VALUE_WIDTH-1:0]           csr_wdata,
   output int                                          error_count,
   output int                                          pending
);

   import sawbd_pkg::*;

   localparam longint VMAX_L = longint'(VALUE_MAX);
   localparam longint VMIN_L = longint'(VALUE_MIN);

   // Shadow registers
   mode_type               cur_mode;
   longint                 start_step_q;
   logic [DECAY_WIDTH-1:0] decay_q;
   longint                 lower_q;
   longint                 upper_q;

   // Shadow state of the ramp
   longint                 ramp_value;
   longint                 ramp_step;

   result_type             expected_results[$];

   initial begin
      error_count = 0;
      pending     = 0;
   end

   function automatic longint limit_to(input longint v, input longint lo, input longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // floor(step * f / 2^16), factor clipped to 1.0
   function automatic longint decayed(input longint stp);
      longint f;
      f = (decay_q > DECAY_ONE) ? longint'(DECAY_ONE) : longint'(decay_q);
      return (stp * f) >>> FRAC_BITS;
   endfunction

   // Apply one item to the shadow state and return the result it produces
   function automatic result_type advance_ramp(input logic func,
                                               input logic signed [VALUE_WIDTH-1:0] preset);
      result_type r;
      longint     sum;
      longint     lo;
      longint     hi;
      longint     nstep;
      r = '0;
      if (func == FUNC_PRESET) begin
         ramp_value = longint'(preset);
         ramp_step  = start_step_q;
      end else begin
         sum = ramp_value + ramp_step;
         lo  = lower_q;
         hi  = upper_q;
         if (lo > hi) begin
            lo = upper_q;
            hi = lower_q;
         end
         case (cur_mode)
            MODE_PLAIN, MODE_DECAY: begin
               r.saturated = (sum > VMAX_L) || (sum < VMIN_L);
               ramp_value  = limit_to(sum, VMIN_L, VMAX_L);
               if (cur_mode == MODE_DECAY) begin
                  ramp_step = decayed(ramp_step);
               end
            end
            MODE_WRAP: begin
               ramp_step = decayed(ramp_step);
               if (sum >= hi) begin
                  r.wrapped = 1'b1;
                  sum = lo + (sum - hi);
               end else if (sum <= lo) begin
                  r.wrapped = 1'b1;
                  sum = hi - (lo - sum);
               end
               ramp_value = limit_to(sum, lo, hi);
            end
            default: begin
               nstep = decayed(ramp_step);
               if (sum >= hi) begin
                  r.reversed = 1'b1;
                  sum = hi - (sum - hi);
               end else if (sum <= lo) begin
                  r.reversed = 1'b1;
                  sum = lo + (lo - sum);
               end
               // negating the most negative step saturates
               if (r.reversed) begin
                  nstep = (nstep == VMIN_L) ? VMAX_L : -nstep;
               end
               ramp_step  = nstep;
               ramp_value = limit_to(sum, lo, hi);
            end
         endcase
      end
      r.value = ramp_value[VALUE_WIDTH-1:0];
      r.step  = ramp_step[VALUE_WIDTH-1:0];
      return r;
   endfunction

   task automatic check_field(input string name, input logic [VALUE_WIDTH-1:0] exp_v,
                              input logic [VALUE_WIDTH-1:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
         error_count++;
      end
   endtask

   // Channel monitor
   always @(posedge clock) begin
      result_type exp_r;
      if (reset) begin
         cur_mode     = MODE_PLAIN;
         start_step_q = 0;
         decay_q      = DECAY_ONE;
         lower_q      = 0;
         upper_q      = longint'(UPPER_RESET);
         ramp_value   = 0;
         ramp_step    = 0;
         expected_results.delete();
      end else begin
         // register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MODE:         cur_mode     = mode_type'(csr_wdata[1:0]);
               CSR_START_STEP:   start_step_q = longint'(signed'(csr_wdata));
               CSR_DECAY_FACTOR: decay_q      = csr_wdata[DECAY_WIDTH-1:0];
               CSR_LOWER_LIMIT:  lower_q      = longint'(signed'(csr_wdata));
               CSR_UPPER_LIMIT:  upper_q      = longint'(signed'(csr_wdata));
               default: ;
            endcase
         end
         // result beat against oldest expectation
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: result beat with nothing expected, value %h step %h",
                        $time, rsp_value_out, rsp_step_out);
               error_count++;
            end else begin
               exp_r = expected_results.pop_front();
               check_field("value_out", exp_r.value, rsp_value_out);
               check_field("step_out", exp_r.step, rsp_step_out);
               check_field("wrapped", VALUE_WIDTH'(exp_r.wrapped),
                           VALUE_WIDTH'(rsp_wrapped));
               check_field("reversed", VALUE_WIDTH'(exp_r.reversed),
                           VALUE_WIDTH'(rsp_reversed));
               check_field("saturated", VALUE_WIDTH'(exp_r.saturated),
                           VALUE_WIDTH'(rsp_saturated));
            end
         end
         // item beat
         if (req_valid && req_ready) begin
            expected_results.push_back(advance_ramp(req_func, req_preset_value));
         end
      end
      pending = expected_results.size();
   end

endmodule

[tb/step_accumulator_wrap_bounce_decay_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// step_accumulator_wrap_bounce_decay_tb
// Stimulus and verdict for the Q16.16 ramp generator with wrap and bounce.
// ----------------------------------------------------------------------------
// A directed pass covers range saturation in both directions, decay rounding
// and an oversized factor, reversed and equal limits, wrap and bounce at both
// limits, overshoot clipping and negation of the most negative step. Random
// phases then reprogram all registers while idle and run ticks with presets
// mixed in. Both sides idle at random, one phase runs with no idling and one
// phase holds the result side off long enough to stall the item channel.
// The checker instance does all prediction and comparison.
// ----------------------------------------------------------------------------
module step_accumulator_wrap_bounce_decay_tb;

   import sawbd_pkg::*;

   localparam int     LIMIT_CYCLES    = 300000;
   localparam int     HOLD_OFF_CYCLES = 60;
   localparam int     FINAL_CYCLES    = 10;
   localparam int     IDLE_PERCENT    = 34;
   localparam int     PHASE_COUNT     = 10;
   localparam int     PHASE_ITEMS     = 75;
   localparam longint VMAX_L          = longint'(VALUE_MAX);
   localparam longint VMIN_L          = longint'(VALUE_MIN);

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_ready;
   logic                             req_func;
   logic signed [VALUE_WIDTH-1:0]    req_preset_value;
   logic                             rsp_valid;
   logic                             rsp_ready;
   logic signed [VALUE_WIDTH-1:0]    rsp_value_out;
   logic signed [VALUE_WIDTH-1:0]    rsp_step_out;
   logic                             rsp_wrapped;
   logic                             rsp_reversed;
   logic                             rsp_saturated;
   logic                             csr_valid;
   logic                             csr_ready;
   logic [CSR_INDEX_WIDTH-1:0]       csr_index;
   logic [VALUE_WIDTH-1:0]           csr_wdata;

   int                               error_count;
   int                               pending;
   int                               cycle_count;
   bit                               steady_run;
   bit                               hold_pending;

   step_accumulator_wrap_bounce_decay dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_preset_value (req_preset_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_value_out    (rsp_value_out),
      .rsp_step_out     (rsp_step_out),
      .rsp_wrapped      (rsp_wrapped),
      .rsp_reversed     (rsp_reversed),
      .rsp_saturated    (rsp_saturated),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   sawbd_ramp_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_preset_value (req_preset_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_value_out    (rsp_value_out),
      .rsp_step_out     (rsp_step_out),
      .rsp_wrapped      (rsp_wrapped),
      .rsp_reversed     (rsp_reversed),
      .rsp_saturated    (rsp_saturated),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .error_count      (error_count),
      .pending          (pending)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Run limit
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
         $display("step_accumulator_wrap_bounce_decay_tb failed");
         $finish;
      end
   end

   // Result side: random back-pressure, plus one long hold-off on request
   always begin
      @(negedge clock);
      if (hold_pending) begin
         hold_pending = 1'b0;
         rsp_ready <= 1'b0;
         repeat (HOLD_OFF_CYCLES) @(negedge clock);
      end
      rsp_ready <= steady_run ? 1'b1 : ($urandom_range(99) >= IDLE_PERCENT);
   end

   // Send one item beat; entered and left at a falling edge, valid left high
   task automatic send_beat(input logic func, input logic [VALUE_WIDTH-1:0] pv);
      while (!steady_run && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= func;
      req_preset_value <= pv;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic tick();
      send_beat(FUNC_TICK, $urandom);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [VALUE_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   // Wait until every expected result has come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
   endtask

   // Reprogram all registers; only called while idle
   task automatic program_regs(input mode_type m, input logic [VALUE_WIDTH-1:0] stp,
                               input logic [DECAY_WIDTH-1:0] dk,
                               input logic [VALUE_WIDTH-1:0] lo,
                               input logic [VALUE_WIDTH-1:0] hi);
      wait_idle();
      csr_write(CSR_MODE, VALUE_WIDTH'(m));
      csr_write(CSR_START_STEP, stp);
      csr_write(CSR_DECAY_FACTOR, VALUE_WIDTH'(dk));
      csr_write(CSR_LOWER_LIMIT, lo);
      csr_write(CSR_UPPER_LIMIT, hi);
      csr_valid <= 1'b0;
   endtask

   // One random setting followed by a run of ticks with presets mixed in;
   // with hold set, the result side stalls while the items go out
   task automatic run_random_phase(input int n_items, input bit hold);
      mode_type               m;
      longint                 center;
      longint                 span;
      longint                 lo;
      longint                 hi;
      longint                 swap_v;
      longint                 stp;
      logic [DECAY_WIDTH-1:0] dk;
      logic [VALUE_WIDTH-1:0] pv;
      m      = mode_type'($urandom_range(3));
      span   = longint'($urandom_range(1, 1 << 22));
      center = longint'($urandom_range(0, 1 << 28)) - (1 << 27);
      lo     = center - span;
      hi     = center + span;
      case ($urandom_range(9))
         0: begin
            lo = longint'($signed($urandom));
            hi = longint'($signed($urandom));
         end
         1: hi = lo;
         2: begin
            lo = VMIN_L;
            hi = VMAX_L;
         end
         3: begin
            swap_v = lo;
            lo     = hi;
            hi     = swap_v;
         end
         default: ;
      endcase
      // step mostly well inside the span so the ramp bounces many times
      case ($urandom_range(9))
         0: stp = VMAX_L;
         1: stp = VMIN_L;
         2: stp = longint'($signed($urandom));
         default: begin
            stp = longint'($urandom_range(0, int'(span / 4) + 1));
            if ($urandom_range(1)) stp = -stp;
         end
      endcase
      case ($urandom_range(7))
         0, 1, 2, 3: dk = DECAY_ONE;
         4:          dk = DECAY_WIDTH'($urandom_range(int'(DECAY_ONE) + 1, 17'h1FFFF));
         5:          dk = DECAY_WIDTH'($urandom_range(0, int'(DECAY_ONE)));
         default:    dk = DECAY_WIDTH'($urandom_range(60000, int'(DECAY_ONE)));
      endcase
      program_regs(m, stp[VALUE_WIDTH-1:0], dk, lo[VALUE_WIDTH-1:0], hi[VALUE_WIDTH-1:0]);
      if (hold) hold_pending = 1'b1;
      for (int i = 0; i < n_items; i++) begin
         if (i == 0 || $urandom_range(99) < 12) begin
            if ($urandom_range(3) == 0) begin
               pv = $urandom;
            end else begin
               pv = VALUE_WIDTH'(center + longint'($urandom_range(0, 1 << 22)) - (1 << 21));
            end
            send_beat(FUNC_PRESET, pv);
         end else begin
            tick();
         end
      end
   endtask

   // Stimulus and verdict
   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_func         = FUNC_TICK;
      req_preset_value = '0;
      rsp_ready        = 1'b0;
      csr_valid        = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      steady_run       = 1'b0;
      hold_pending     = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset state and plain accumulate with zero step
      tick();
      send_beat(FUNC_PRESET, VALUE_MAX);
      tick();

      // saturation at the top of the range
      program_regs(MODE_PLAIN, VALUE_MAX, DECAY_ONE, '0, UPPER_RESET);
      send_beat(FUNC_PRESET, VALUE_MAX);
      tick();
      tick();

      // saturation at the bottom, factor above 1.0 acts as 1.0
      program_regs(MODE_DECAY, VALUE_MIN, 17'h1FFFF, '0, UPPER_RESET);
      send_beat(FUNC_PRESET, VALUE_MIN);
      tick();

      // decay of a small negative step rounds toward minus infinity
      program_regs(MODE_DECAY, -32'sd3, 17'd1, '0, UPPER_RESET);
      send_beat(FUNC_PRESET, '0);
      tick();
      tick();

      // wrap upward with reversed limits [-1.0, 3.0]
      program_regs(MODE_WRAP, 32'sh0001_8000, DECAY_ONE, 32'sh0003_0000, -32'sh0001_0000);
      send_beat(FUNC_PRESET, '0);
      tick();
      tick();
      tick();

      // wrap downward, zero decay factor
      program_regs(MODE_WRAP, -32'sh0001_8000, '0, -32'sh0001_0000, 32'sh0003_0000);
      send_beat(FUNC_PRESET, '0);
      tick();

      // bounce on equal limits with the most negative step
      program_regs(MODE_BOUNCE, VALUE_MIN, DECAY_ONE, 32'sh0005_0000, 32'sh0005_0000);
      send_beat(FUNC_PRESET, '0);
      tick();
      tick();

      // bounce at the full number range
      program_regs(MODE_BOUNCE, VALUE_MAX, DECAY_ONE, VALUE_MIN, VALUE_MAX);
      send_beat(FUNC_PRESET, VALUE_MAX);
      tick();

      // random phases
      for (int p = 0; p < PHASE_COUNT; p++) begin
         steady_run = (p == 3);
         run_random_phase(PHASE_ITEMS, p == 6);
      end
      steady_run = 1'b0;

      wait_idle();
      repeat (FINAL_CYCLES) @(negedge clock);
      if (error_count == 0 && pending == 0) begin
         $display("step_accumulator_wrap_bounce_decay_tb passed");
      end else begin
         $display("step_accumulator_wrap_bounce_decay_tb failed");
      end
      $finish;
   end

endmodule
